[hdl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared field widths, saturation limits and channel payload types of the
// sample standard deviation unit.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int ELEV_W  = 24;   // elevation field, signed Q14.10
   localparam int ROUGH_W = 24;   // roughness field, unsigned Q14.10
   localparam int COUNT_W = 11;   // sample_count field
   localparam int QW      = 64;   // squared-deviation sum and divider width

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [ROUGH_W-1:0] ROUGH_MAX = '1;
   localparam logic [QW-1:0]      QUAD_MAX  = '1;

   typedef struct packed {
      logic signed [ELEV_W-1:0] elevation;
      logic                     last_sample;
   } req_type;

   typedef struct packed {
      logic [ROUGH_W-1:0] roughness;
      logic [COUNT_W-1:0] sample_count;
      logic               overflowed;
   } rsp_type;

endpackage

[hdl/sample_standard_deviation_unit.sv]
// ----------------------------------------------------------------------------
// sample_standard_deviation_unit
// Population standard deviation of one marked set of Q14.10 elevation
// samples, returned as one Q14.10 result with sample count and drop flag.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  elevation, last_sample
//   rsp      out        rsp_valid/rsp_ready  roughness, sample_count, overflowed
//
// The intake takes one sample transfer per cycle while req_ready is high,
// into one bank of a two-bank sample RAM. For each set the sequencer takes
// the set, runs the shared radix-2 divider (64 steps) for the mean, scans
// the stored samples through the RAM read port and its three-stage pipe,
// runs the divider again for the variance, and finishes with a square
// root of 32 steps and a capture; the result register then holds until
// the rsp transfer.
// While the sequencer works on one bank, the next set loads into the other;
// req_ready drops only while both banks hold sets not yet scanned.
// Reset clears the counters, the descriptor queue and the sequencer; the
// sample RAM is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module sample_standard_deviation_unit #(
   parameter int MAX_SAMPLES = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssd_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssd_pkg::rsp_type rsp
);
   import ssd_pkg::*;

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int IW   = $clog2(MAX_SAMPLES);
   localparam int SUMW = SAMPLE_BITS + CW;
   localparam int QDW  = SUMW + CW + 2;
   localparam int RAM_DEPTH = 2 * (2 ** IW);
   localparam logic [COUNT_W-1:0] OVF_COUNT =
      (MAX_SAMPLES > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(MAX_SAMPLES);

   // sample RAM: write from intake, read from the scan
   logic                   ram_we;
   logic [IW:0]            ram_waddr;
   logic [SAMPLE_BITS-1:0] ram_wdata;
   logic                   ram_re;
   logic [IW:0]            ram_raddr;
   logic [SAMPLE_BITS-1:0] ram_rdata;

   // set descriptors
   logic                   q_push, q_can_push, q_pop, q_valid;
   logic                   f_bank, f_dropped;
   logic [CW-1:0]          f_count;
   logic signed [SUMW-1:0] f_sum;
   logic [QDW-1:0]         q_push_data, q_pop_data;
   logic                   b_bank, b_dropped;
   logic [CW-1:0]          b_count;
   logic signed [SUMW-1:0] b_sum;

   // shared divider
   logic                   div_start, div_done;
   logic [QW-1:0]          div_dividend, div_quot;
   logic [CW-1:0]          div_divisor;

   ssd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ssd_front #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .q_can_push (q_can_push),
      .q_push     (q_push),
      .q_bank     (f_bank),
      .q_count    (f_count),
      .q_sum      (f_sum),
      .q_dropped  (f_dropped)
   );

   // pack descriptor: bank, count, sum, drop flag
   assign q_push_data = {f_bank, f_count, f_sum, f_dropped};

   ssd_queue #(
      .WIDTH (QDW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .can_push  (q_can_push),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_pop_data)
   );

   assign b_bank    = q_pop_data[QDW-1];
   assign b_count   = q_pop_data[QDW-2 -: CW];
   assign b_sum     = signed'(q_pop_data[SUMW:1]);
   assign b_dropped = q_pop_data[0];

   ssd_divider #(
      .DIVISOR_W (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   ssd_back #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_bank       (b_bank),
      .q_count      (b_count),
      .q_sum        (b_sum),
      .q_dropped    (b_dropped),
      .q_pop        (q_pop),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_quot     (div_quot),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp          (rsp)
   );

   // intake never pushes a set descriptor into a full queue
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_can_push)
      else $error("descriptor pushed into full queue");

   // intake and scan always work on different banks
   a_bank_split: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr[IW] != ram_raddr[IW]))
      else $error("intake and scan share a RAM bank");

   // every result covers at least one stored sample
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.sample_count != '0))
      else $error("result with zero sample count");

   // a drop can only happen with a full bank
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.overflowed) |-> (rsp.sample_count == OVF_COUNT))
      else $error("drop flag set without a full bank");

endmodule

[hdl/ssd_ram.sv]
// ----------------------------------------------------------------------------
// ssd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module ssd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/ssd_front.sv]
// ----------------------------------------------------------------------------
// ssd_front
// Sample intake: stores each sample in the current RAM bank while it has
// room, keeps the running sum, count and drop flag, and pushes a set
// descriptor on the marked sample.
// ----------------------------------------------------------------------------
module ssd_front #(
   parameter  int MAX_SAMPLES = 1024,
   parameter  int SAMPLE_BITS = 24,
   localparam int CW          = $clog2(MAX_SAMPLES + 1),
   localparam int IW          = $clog2(MAX_SAMPLES),
   localparam int SUMW        = SAMPLE_BITS + CW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ssd_pkg::req_type       req,
   output logic                   ram_we,
   output logic [IW:0]            ram_waddr,
   output logic [SAMPLE_BITS-1:0] ram_wdata,
   input  logic                   q_can_push,
   output logic                   q_push,
   output logic                   q_bank,
   output logic [CW-1:0]          q_count,
   output logic signed [SUMW-1:0] q_sum,
   output logic                   q_dropped
);
   import ssd_pkg::*;

   localparam int MW = (SAMPLE_BITS > ELEV_W) ? SAMPLE_BITS : ELEV_W;

   logic [CW-1:0]           count_ff, count_in, count_next;
   logic signed [SUMW-1:0]  sum_ff, sum_in, sum_next;
   logic                    drop_ff, drop_in, drop_next;
   logic                    bank_ff, bank_in;
   logic [MW-1:0]           raw_wide;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                    xfer;
   logic                    has_room;

   // a bank is free whenever the descriptor queue has room
   assign req_ready = q_can_push;
   assign xfer      = req_valid & req_ready;

   // keep only the low SAMPLE_BITS bits, then treat them as two's complement
   assign raw_wide = MW'($unsigned(req.elevation));
   assign sample   = signed'(raw_wide[SAMPLE_BITS-1:0]);
   assign has_room = count_ff < CW'(MAX_SAMPLES);

   assign ram_we    = xfer & has_room;
   assign ram_waddr = {bank_ff, count_ff[IW-1:0]};
   assign ram_wdata = sample;

   always_comb begin
      count_next = count_ff;
      sum_next   = sum_ff;
      drop_next  = drop_ff;
      if (has_room) begin
         count_next = count_ff + CW'(1);
         sum_next   = sum_ff + SUMW'(sample);
      end else begin
         drop_next = 1'b1;
      end

      count_in = count_ff;
      sum_in   = sum_ff;
      drop_in  = drop_ff;
      bank_in  = bank_ff;
      if (xfer) begin
         if (req.last_sample) begin
            // close the set and move to the other bank
            count_in = '0;
            sum_in   = '0;
            drop_in  = 1'b0;
            bank_in  = ~bank_ff;
         end else begin
            count_in = count_next;
            sum_in   = sum_next;
            drop_in  = drop_next;
         end
      end
   end

   assign q_push    = xfer & req.last_sample;
   assign q_bank    = bank_ff;
   assign q_count   = count_next;
   assign q_sum     = sum_next;
   assign q_dropped = drop_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
         bank_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         drop_ff  <= drop_in;
         bank_ff  <= bank_in;
      end
   end

endmodule

[hdl/ssd_queue.sv]
// ----------------------------------------------------------------------------
// ssd_queue
// Two-entry descriptor FIFO between intake and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module ssd_queue #(
   parameter int WIDTH = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             can_push,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign can_push  = fill_ff != 2'd2;
   assign pop_valid = fill_ff != 2'd0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/ssd_divider.sv]
// ----------------------------------------------------------------------------
// ssd_divider
// Radix-2 restoring divider, one quotient bit per cycle, shared by the
// mean and variance steps.
// ----------------------------------------------------------------------------
module ssd_divider #(
   parameter int DIVISOR_W = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [ssd_pkg::QW-1:0] dividend,
   input  logic [DIVISOR_W-1:0]   divisor,
   output logic                   done,
   output logic [ssd_pkg::QW-1:0] quotient
);
   import ssd_pkg::*;

   localparam int CTW = $clog2(QW + 1);

   logic [QW-1:0]        quot_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [CTW-1:0]       steps_ff, steps_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   rem_sh;
   logic [DIVISOR_W:0]   rem_diff;
   logic                 fits;

   // shift in the next dividend bit, subtract if the divisor fits
   assign rem_sh   = {rem_ff, quot_ff[QW-1]};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign fits     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      steps_in = steps_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         steps_in = CTW'(QW);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         steps_in = steps_ff - CTW'(1);
         if (steps_ff == CTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         steps_ff <= steps_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= {quot_ff[QW-2:0], fits};
         rem_ff  <= fits ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

[hdl/ssd_back.sv]
// ----------------------------------------------------------------------------
// ssd_back
// Per-set sequencer: mean division, squared-deviation scan over the stored
// bank, variance division, iterative square root, result register.
// ----------------------------------------------------------------------------
module ssd_back #(
   parameter  int MAX_SAMPLES = 1024,
   parameter  int SAMPLE_BITS = 24,
   localparam int CW          = $clog2(MAX_SAMPLES + 1),
   localparam int IW          = $clog2(MAX_SAMPLES),
   localparam int SUMW        = SAMPLE_BITS + CW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  logic                   q_bank,
   input  logic [CW-1:0]          q_count,
   input  logic signed [SUMW-1:0] q_sum,
   input  logic                   q_dropped,
   output logic                   q_pop,
   output logic                   div_start,
   output logic [ssd_pkg::QW-1:0] div_dividend,
   output logic [CW-1:0]          div_divisor,
   input  logic                   div_done,
   input  logic [ssd_pkg::QW-1:0] div_quot,
   output logic                   ram_re,
   output logic [IW:0]            ram_raddr,
   input  logic [SAMPLE_BITS-1:0] ram_rdata,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ssd_pkg::rsp_type       rsp
);
   import ssd_pkg::*;

   localparam int DW = SAMPLE_BITS + 1;
   localparam int PW = 2 * SAMPLE_BITS;
   localparam int AW = PW + CW;
   localparam int XW = (AW > QW) ? AW : QW;
   localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MEAN = 6'b000010,
      ST_SCAN = 6'b000100,
      ST_VAR  = 6'b001000,
      ST_ROOT = 6'b010000,
      ST_DONE = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic                          bank_ff;
   logic [CW-1:0]                 n_ff;
   logic                          neg_ff;
   logic                          drop_ff;
   logic signed [SAMPLE_BITS-1:0] mean_ff;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic                          v1_ff, v2_ff, v3_ff;
   logic [SAMPLE_BITS-1:0]        ad_ff;
   logic [PW-1:0]                 sq_ff;
   logic [AW-1:0]                 acc_ff;
   logic [QW-1:0]                 x_ff, root_ff, rbit_ff;
   rsp_type                       rsp_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [SUMW-1:0]        neg_sum;
   logic [SUMW-1:0]               abs_sum;
   logic [XW-1:0]                 acc_wide;
   logic [QW-1:0]                 acc_sat;
   logic                          scan_end;
   logic signed [DW-1:0]          diff, neg_diff;
   logic [SAMPLE_BITS-1:0]        ad_in;
   logic [PW-1:0]                 sq_in;
   logic signed [DW-1:0]          quot_s, mean_full;
   logic [QW-1:0]                 trial;
   logic                          take;
   logic [ROUGH_W-1:0]            rough;
   logic [NW-1:0]                 n_wide;
   logic [COUNT_W-1:0]            count_sat;

   // mean is formed on the magnitude, sign restored afterward
   assign neg_sum = -q_sum;
   assign abs_sum = q_sum[SUMW-1] ? unsigned'(neg_sum) : unsigned'(q_sum);

   assign acc_wide = XW'(acc_ff);
   assign acc_sat  = (acc_wide > XW'(QUAD_MAX)) ? QUAD_MAX : acc_wide[QW-1:0];

   assign ram_re    = (state_ff == ST_SCAN) && (idx_ff != n_ff);
   assign ram_raddr = {bank_ff, idx_ff[IW-1:0]};
   assign scan_end  = (state_ff == ST_SCAN) && (idx_ff == n_ff) && !v1_ff && !v2_ff && !v3_ff;

   // bank is released once the scan has drained
   assign q_pop = scan_end;

   assign div_start    = ((state_ff == ST_IDLE) && q_valid) || scan_end;
   assign div_dividend = (state_ff == ST_IDLE) ? QW'(abs_sum) : acc_sat;
   assign div_divisor  = (state_ff == ST_IDLE) ? q_count : n_ff;

   assign diff     = DW'(signed'(ram_rdata)) - DW'(mean_ff);
   assign neg_diff = -diff;
   assign ad_in    = diff[DW-1] ? neg_diff[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
   assign sq_in    = PW'(ad_ff) * PW'(ad_ff);

   assign quot_s    = signed'({1'b0, div_quot[SAMPLE_BITS-1:0]});
   assign mean_full = neg_ff ? -quot_s : quot_s;

   assign trial = root_ff + rbit_ff;
   assign take  = x_ff >= trial;

   assign rough     = (root_ff[QW-1:ROUGH_W] != '0) ? ROUGH_MAX : root_ff[ROUGH_W-1:0];
   assign n_wide    = NW'(n_ff);
   assign count_sat = (n_wide > NW'(COUNT_MAX)) ? COUNT_MAX : n_wide[COUNT_W-1:0];

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (div_done) begin
               state_in = ST_SCAN;
               idx_in   = '0;
            end
         end
         ST_SCAN: begin
            if (ram_re) begin
               idx_in = idx_ff + CW'(1);
            end
            if (scan_end) begin
               state_in = ST_VAR;
            end
         end
         ST_VAR: begin
            if (div_done) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rbit_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = state_in == ST_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         v1_ff        <= ram_re;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && q_valid) begin
         bank_ff <= q_bank;
         n_ff    <= q_count;
         neg_ff  <= q_sum[SUMW-1];
         drop_ff <= q_dropped;
      end
      if ((state_ff == ST_MEAN) && div_done) begin
         mean_ff <= signed'(mean_full[SAMPLE_BITS-1:0]);
         acc_ff  <= '0;
      end else if (v3_ff) begin
         acc_ff <= acc_ff + AW'(sq_ff);
      end
      if (v1_ff) begin
         ad_ff <= ad_in;
      end
      if (v2_ff) begin
         sq_ff <= sq_in;
      end
      if ((state_ff == ST_VAR) && div_done) begin
         x_ff    <= div_quot;
         root_ff <= '0;
         rbit_ff <= QW'(1) << (QW - 2);
      end else if (state_ff == ST_ROOT) begin
         if (rbit_ff != '0) begin
            if (take) begin
               x_ff    <= x_ff - trial;
               root_ff <= (root_ff >> 1) + rbit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            rbit_ff <= rbit_ff >> 2;
         end else begin
            rsp_ff.roughness    <= rough;
            rsp_ff.sample_count <= count_sat;
            rsp_ff.overflowed   <= drop_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
